// File: rtl/core/stable_priority_queue_top_defines.svh
// Assertion macros shared by the queue RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expr holds on every enabled edge
`define SPQ_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// ante implies cons in the same cycle
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_HOLDS(label, clk, rst_n, expr, msg)
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // field widths
    localparam int PRIO_W      = 8;
    localparam int PAYLOAD_W   = 32;
    localparam int RANK_W      = 5;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int REQ_W       = 2;

    localparam int S_TDATA_W = 48;  // prio, payload, rank = 45 bits
    localparam int S_TUSER_W = REQ_W;
    localparam int M_USED_W  = STATUS_W + 1 + PRIO_W + PAYLOAD_W + COUNT_OUT_W;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;
    localparam int S_PAD_W   = S_TDATA_W - (PRIO_W + PAYLOAD_W + RANK_W);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_ERASE = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_LIMIT  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_EMPTY  = 3'd3,
        STAT_NORANK = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_SCAN,
        S_PUSH_PLACE,
        S_REM_MOVE,
        S_FINISH,
        S_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_TAIL,
        IDX_POS,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [2:0] {
        RD_HEAD,
        RD_TAIL,
        RD_POS_P1,
        RD_IDX_M1,
        RD_IDX_P2
    } rd_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW_AT_0,
        WR_NEW_AT_IDX_P1,
        WR_OLD_AT_IDX_P1,
        WR_OLD_AT_IDX
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        idx_op_t idx_op;
        rd_op_t  rd_op;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
        logic    set_status;
        status_t status;
        logic    load_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        req_t req_type;
        logic over_limit;
        logic full;
        logic empty;
        logic rank_bad;
        logic pos_last;
        logic scan_stop;
        logic idx_zero;
        logic move_last;
    } dp_flags_t;

endpackage

// File: rtl/core/stable_priority_queue_top.sv
`timescale 1ns / 1ps

// Stable priority queue. Holds up to CAPACITY entries (8-bit priority plus a
// 32-bit handle) sorted by descending priority, FIFO among equal priorities,
// in one dual-port RAM (one write, one registered read per cycle). Each
// request on the s_ channel (push, pop head, erase by 1-based rank, clear)
// returns exactly one result on the m_ channel: status, head entry after the
// request (zeros when empty) and entry count (low 5 bits). Requests are
// handled one at a time; s_tready is high only while the block is idle, and
// a finished result sits in an output register so the next request can be
// taken while it waits. A push into a non-empty list moves each entry of lower
// priority down one slot (one RAM slot per cycle, scanning from the tail; the
// scan either stops on the first entry it does not move or ends with a separate
// step that places the new entry at the head); pop/erase (pop is rank 1) shifts
// the entries behind the rank up, one slot shifted up per cycle. The single RAM
// write port sets that per-slot rate. priority_limit (reset 255) is to be
// written through cfg_wr_en/cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
module stable_priority_queue_top #(
    parameter int CAPACITY = 16  // entries, 2 to 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // priority limit register
    input  logic                          cfg_wr_en,
    input  logic [spq_pkg::PRIO_W-1:0]    cfg_wr_data,

    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] priority_req, [39:8] payload, [44:40] rank, [47:45] zero
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [spq_pkg::S_TUSER_W-1:0] s_tuser,

    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [3] top_valid, [11:4] top_priority,
    // [43:12] top_payload, [48:44] entry_count, [55:49] zero
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);

    import spq_pkg::*;

    dp_cmd_t                cmd;
    dp_flags_t              flags;

    // unpacked request fields
    req_t                   in_req_type;
    logic [PRIO_W-1:0]      in_priority_req;
    logic [PAYLOAD_W-1:0]   in_payload;
    logic [RANK_W-1:0]      in_rank;

    // result fields
    status_t                out_status;
    logic                   out_top_valid;
    logic [PRIO_W-1:0]      out_top_priority;
    logic [PAYLOAD_W-1:0]   out_top_payload;
    logic [COUNT_OUT_W-1:0] out_entry_count;

    assign in_req_type     = req_t'(s_tuser);
    assign in_priority_req = s_tdata[PRIO_W-1:0];
    assign in_payload      = s_tdata[PRIO_W +: PAYLOAD_W];
    assign in_rank         = s_tdata[PRIO_W + PAYLOAD_W +: RANK_W];

    // control: request handshake, sequencing, result valid
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    // storage, count, limit and result register
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_req_type      (in_req_type),
        .in_priority_req  (in_priority_req),
        .in_payload       (in_payload),
        .in_rank          (in_rank),
        .cmd              (cmd),
        .flags            (flags),
        .out_status       (out_status),
        .out_top_valid    (out_top_valid),
        .out_top_priority (out_top_priority),
        .out_top_payload  (out_top_payload),
        .out_entry_count  (out_entry_count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_entry_count, out_top_payload,
                      out_top_priority, out_top_valid, out_status};

endmodule

// File: rtl/core/spq_ram.sv
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps
`include "stable_priority_queue_top_defines.svh"

module spq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  spq_pkg::dp_flags_t flags,
    output spq_pkg::dp_cmd_t   cmd
);

    import spq_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (flags.req_type)
                    REQ_PUSH: begin
                        if (flags.over_limit || flags.full || flags.empty) begin
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_PUSH_SCAN;
                        end
                    end
                    REQ_POP: begin
                        if (flags.empty || flags.pos_last) begin
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_REM_MOVE;
                        end
                    end
                    REQ_ERASE: begin
                        if (flags.rank_bad || flags.pos_last) begin
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_REM_MOVE;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PUSH_SCAN: begin
                if (flags.scan_stop) begin
                    state_next = S_FINISH;
                end else if (flags.idx_zero) begin
                    state_next = S_PUSH_PLACE;
                end
            end
            S_PUSH_PLACE: begin
                state_next = S_FINISH;
            end
            S_REM_MOVE: begin
                if (flags.move_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                state_next = S_OUTPUT;
            end
            S_OUTPUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.rd_op      = RD_HEAD;
        cmd.wr_op      = WR_NONE;
        cmd.cnt_op     = CNT_HOLD;
        cmd.status     = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_req = s_tvalid;
            end
            S_DECODE: begin
                cmd.set_status = 1'b1;
                unique case (flags.req_type) inside
                    REQ_PUSH: begin
                        if (flags.over_limit) begin
                            cmd.status = STAT_LIMIT;
                        end else if (flags.full) begin
                            cmd.status = STAT_FULL;
                        end else if (flags.empty) begin
                            cmd.wr_op  = WR_NEW_AT_0;
                            cmd.cnt_op = CNT_INC;
                        end else begin
                            cmd.idx_op = IDX_TAIL;
                            cmd.rd_op  = RD_TAIL;
                        end
                    end
                    REQ_POP, REQ_ERASE: begin
                        if (flags.req_type == REQ_POP && flags.empty) begin
                            cmd.status = STAT_EMPTY;
                        end else if (flags.req_type == REQ_ERASE && flags.rank_bad) begin
                            cmd.status = STAT_NORANK;
                        end else if (flags.pos_last) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.idx_op = IDX_POS;
                            cmd.rd_op  = RD_POS_P1;
                        end
                    end
                    default: begin
                        cmd.cnt_op = CNT_CLR;
                    end
                endcase
            end
            S_PUSH_SCAN: begin
                if (flags.scan_stop) begin
                    cmd.wr_op  = WR_NEW_AT_IDX_P1;
                    cmd.cnt_op = CNT_INC;
                end else begin
                    cmd.wr_op = WR_OLD_AT_IDX_P1;
                    if (!flags.idx_zero) begin
                        cmd.idx_op = IDX_DEC;
                        cmd.rd_op  = RD_IDX_M1;
                    end
                end
            end
            S_PUSH_PLACE: begin
                cmd.wr_op  = WR_NEW_AT_0;
                cmd.cnt_op = CNT_INC;
            end
            S_REM_MOVE: begin
                cmd.wr_op = WR_OLD_AT_IDX;
                if (flags.move_last) begin
                    cmd.cnt_op = CNT_DEC;
                end else begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_op  = RD_IDX_P2;
                end
            end
            S_FINISH: begin
                cmd.rd_op = RD_HEAD;
            end
            S_OUTPUT: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd.rd_op = RD_HEAD;
            end
        endcase
    end

    `SPQ_ASSERT_NEXT(a_accept_to_decode, aclk, aresetn, s_tvalid && s_tready, state_reg == S_DECODE, "accepted request did not go to decode")
    `SPQ_ASSERT_NEXT(a_output_done, aclk, aresetn, state_reg == S_OUTPUT && out_free, state_reg == S_IDLE && m_tvalid_reg, "result load did not raise m_tvalid")
    `SPQ_ASSERT_IMPLY(a_place_after_scan, aclk, aresetn, state_reg == S_PUSH_PLACE, $past(state_reg) == S_PUSH_SCAN, "head placement without a scan")

endmodule

// File: rtl/core/spq_datapath.sv
`timescale 1ns / 1ps
`include "stable_priority_queue_top_defines.svh"

module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [spq_pkg::PRIO_W-1:0]      cfg_wr_data,
    input  spq_pkg::req_t                   in_req_type,
    input  logic [spq_pkg::PRIO_W-1:0]      in_priority_req,
    input  logic [spq_pkg::PAYLOAD_W-1:0]   in_payload,
    input  logic [spq_pkg::RANK_W-1:0]      in_rank,
    input  spq_pkg::dp_cmd_t                cmd,
    output spq_pkg::dp_flags_t              flags,
    output spq_pkg::status_t                out_status,
    output logic                            out_top_valid,
    output logic [spq_pkg::PRIO_W-1:0]      out_top_priority,
    output logic [spq_pkg::PAYLOAD_W-1:0]   out_top_payload,
    output logic [spq_pkg::COUNT_OUT_W-1:0] out_entry_count
);

    import spq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = CNT_W + 1;
    localparam int CMP_W = (EW > RANK_W) ? EW : RANK_W;

    logic [PRIO_W-1:0]      limit_reg;
    req_t                   req_type_reg;
    logic [PRIO_W-1:0]      prio_reg;
    logic [PAYLOAD_W-1:0]   payload_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    status_t                status_reg;

    status_t                out_status_reg;
    logic                   out_valid_reg;
    logic [PRIO_W-1:0]      out_prio_reg;
    logic [PAYLOAD_W-1:0]   out_payload_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic [IDX_W-1:0] pos_w, pos_p1, tail, idx_p1, idx_p2, idx_m1;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    entry_t           wr_data, rd_data, new_entry;
    logic             empty_w;

    // position of the first entry removed by pop / erase
    assign pos_w  = (req_type_reg == REQ_ERASE)
                  ? IDX_W'(CMP_W'(rank_reg) - CMP_W'(1)) : '0;
    assign pos_p1 = IDX_W'(CMP_W'(pos_w) + CMP_W'(1));
    assign tail   = IDX_W'(count_reg - CNT_W'(1));
    assign idx_p1 = IDX_W'(CMP_W'(idx_reg) + CMP_W'(1));
    assign idx_p2 = IDX_W'(CMP_W'(idx_reg) + CMP_W'(2));
    assign idx_m1 = IDX_W'(idx_reg - IDX_W'(1));
    assign empty_w = (count_reg == '0);

    assign new_entry.payload = payload_reg;
    assign new_entry.prio    = prio_reg;

    always_comb begin
        flags.req_type   = req_type_reg;
        flags.over_limit = prio_reg > limit_reg;
        flags.full       = count_reg == CNT_W'(CAPACITY);
        flags.empty      = empty_w;
        flags.rank_bad   = (rank_reg == '0) || (CMP_W'(rank_reg) > CMP_W'(count_reg));
        flags.pos_last   = (CMP_W'(pos_w) + CMP_W'(1)) >= CMP_W'(count_reg);
        flags.scan_stop  = rd_data.prio >= prio_reg;
        flags.idx_zero   = (idx_reg == '0);
        flags.move_last  = (CMP_W'(idx_reg) + CMP_W'(2)) >= CMP_W'(count_reg);
    end

    always_comb begin
        case (cmd.rd_op)
            RD_TAIL:   rd_addr = tail;
            RD_POS_P1: rd_addr = pos_p1;
            RD_IDX_M1: rd_addr = idx_m1;
            RD_IDX_P2: rd_addr = idx_p2;
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_entry;
        case (cmd.wr_op)
            WR_NEW_AT_0: begin
                wr_addr = '0;
            end
            WR_NEW_AT_IDX_P1: begin
                wr_addr = idx_p1;
            end
            WR_OLD_AT_IDX_P1: begin
                wr_addr = idx_p1;
                wr_data = rd_data;
            end
            WR_OLD_AT_IDX: begin
                wr_addr = idx_reg;
                wr_data = rd_data;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (cmd.idx_op)
            IDX_TAIL: idx_next = tail;
            IDX_POS:  idx_next = pos_w;
            IDX_DEC:  idx_next = idx_m1;
            IDX_INC:  idx_next = idx_p1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    spq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '1;
            count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_req) begin
            req_type_reg <= in_req_type;
            prio_reg     <= in_priority_req;
            payload_reg  <= in_payload;
            rank_reg     <= in_rank;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out) begin
            out_status_reg  <= status_reg;
            out_valid_reg   <= !empty_w;
            out_prio_reg    <= empty_w ? '0 : rd_data.prio;
            out_payload_reg <= empty_w ? '0 : rd_data.payload;
            out_count_reg   <= COUNT_OUT_W'(count_reg);
        end
    end

    assign out_status       = out_status_reg;
    assign out_top_valid    = out_valid_reg;
    assign out_top_priority = out_prio_reg;
    assign out_top_payload  = out_payload_reg;
    assign out_entry_count  = out_count_reg;

    `SPQ_ASSERT_HOLDS(a_count_bound, aclk, aresetn, CMP_W'(count_reg) <= CMP_W'(CAPACITY), "entry count above capacity")
    `SPQ_ASSERT_IMPLY(a_write_in_range, aclk, aresetn, wr_en, CMP_W'(wr_addr) <= CMP_W'(count_reg), "slot write beyond the tail")
    `SPQ_ASSERT_IMPLY(a_empty_top_zero, aclk, aresetn, $past(cmd.load_out) && !out_valid_reg, out_prio_reg == '0 && out_payload_reg == '0, "empty result carries a head entry")

endmodule
